// ===== hdl/i2cee_pkg.sv =====
// shared types, constants and helpers of the i2c eeprom transfer sequencer
package i2cee_pkg;

    localparam int MEM_BYTES_DEF  = 2048;
    localparam int PAGE_BYTES_DEF = 16;
    localparam int BLOCK_BYTES    = 256;
    localparam int ADDR_W         = 12;
    localparam int CLEN_W         = 9;
    localparam int IDX_W          = 11;
    localparam int RES_DEPTH      = 4;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_HOST = 2'd1,
        REQ_BUS  = 2'd2,
        REQ_TICK = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_STOP  = 3'd1,
        K_WRITE = 3'd2,
        K_READ  = 3'd3,
        K_WANT  = 3'd4,
        K_DATA  = 3'd5,
        K_DONE  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NACK    = 3'd1,
        ST_ADDR    = 3'd2,
        ST_SIZE    = 3'd3,
        ST_TIMEOUT = 3'd4
    } stat_t;

    typedef enum logic [4:0] {
        PH_IDLE, PH_RD_START, PH_RD_DEV, PH_RD_WORD, PH_RD_RESTART, PH_RD_DEVR,
        PH_RD_DATA, PH_RD_STOP, PH_CMP_HOST, PH_WR_START, PH_WR_DEV, PH_WR_WORD,
        PH_WR_HOST, PH_WR_DATA, PH_WR_STOP, PH_PL_START, PH_PL_DEV, PH_PL_OK,
        PH_PL_FAIL, PH_PL_TICK, PH_ERR_STOP
    } phase_t;

    localparam logic CFG_DEVICE_BASE = 1'b0;
    localparam logic CFG_POLL_LIMIT  = 1'b1;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic             ack;
        logic [IDX_W-1:0] idx;
        stat_t            status;
        logic             last;
    } res_t;

    function automatic res_t mk_res(kind_t k, logic [7:0] d, logic a,
                                    logic [IDX_W-1:0] i, stat_t s);
        res_t r;
        r.kind   = k;
        r.data   = d;
        r.ack    = a;
        r.idx    = i;
        r.status = s;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/i2cee_page_buf.sv =====
// page buffer memory, one write and one registered read per cycle with forwarding
module i2cee_page_buf #(
    parameter int PAGE_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(PAGE_BYTES)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic [$clog2(PAGE_BYTES)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);
    logic [7:0] mem [PAGE_BYTES];
    logic [7:0] rd_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, a same-cycle write to the same entry is forwarded
    always_ff @(posedge aclk) begin
        if (wr_en && wr_addr == rd_addr) begin
            rd_reg <= wr_data;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;
endmodule

// ===== hdl/i2cee_res_fifo.sv =====
// result queue, takes up to two results per cycle and gives one
module i2cee_res_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_cnt,
    input  i2cee_pkg::res_t  push0,
    input  i2cee_pkg::res_t  push1,
    output logic             room2,
    output logic             pop_valid,
    input  logic             pop_ready,
    output i2cee_pkg::res_t  pop_data,
    output logic [2:0]       level
);
    import i2cee_pkg::*;

    res_t       q [RES_DEPTH];
    logic [1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] wptr1;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = cnt_reg != 3'd0;
    assign pop_data  = q[rptr_reg];
    assign room2     = cnt_reg <= 3'(RES_DEPTH - 2);
    assign level     = cnt_reg;
    assign wptr1     = wptr_reg + 2'd1;

    // pointer and level update
    always_comb begin
        wptr_next = wptr_reg + push_cnt;
        rptr_next = rptr_reg + {1'b0, pop};
        cnt_next  = cnt_reg + {1'b0, push_cnt} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q[wptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            q[wptr1] <= push1;
        end
    end
endmodule

// ===== hdl/i2c_eeprom_transfer_sequencer.sv =====
// top level of the i2c eeprom transfer sequencer: control state machine
//
//  channel  handshake            payload
//  s_       s_valid / s_ready    req_type op start_addr transfer_len host_byte bus_ack bus_byte
//  m_       m_valid / m_ready    out_kind out_byte read_ack data_index status last
//  cfg_     cfg_valid / cfg_ready cfg_index cfg_data
//
// one item a cycle: every item is handled in the cycle it is accepted and its
// zero to two results go into a four-entry result queue; s_ready is high while
// the queue has room for two results. the page buffer is a registered-read
// ram read one item ahead, with forwarding of a same-cycle write.
// reset is synchronous and clears the control state; no clearing pass.
module i2c_eeprom_transfer_sequencer #(
    parameter int MEM_BYTES  = i2cee_pkg::MEM_BYTES_DEF,
    parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_start_addr,
    input  logic [15:0] s_transfer_len,
    input  logic [7:0]  s_host_byte,
    input  logic        s_bus_ack,
    input  logic [7:0]  s_bus_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [7:0]  m_out_byte,
    output logic        m_read_ack,
    output logic [10:0] m_data_index,
    output logic [2:0]  m_status,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import i2cee_pkg::*;

    localparam int PIDX_W = $clog2(PAGE_BYTES);

    phase_t              phase_reg, phase_next;
    op_t                 oper_reg, oper_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next, rem_reg, rem_next, off_reg, off_next;
    logic [CLEN_W-1:0]   clen_reg, clen_next, cpos_reg, cpos_next;
    logic [7:0]          poll_reg, poll_next;
    logic                diff_reg, diff_next;
    logic [7:0]          dev_base_reg, poll_limit_reg;

    logic                acc;
    req_t                req;
    logic [1:0]          n_res;
    res_t                r0, r1, p0, p1, q_out;
    logic                room2;
    logic [2:0]          q_level;

    logic                buf_we;
    logic [PIDX_W-1:0]   buf_waddr, buf_raddr;
    logic [7:0]          buf_wdata, buf_rdata;

    // chunk start inputs and results
    logic                bc_sel_cmd;
    op_t                 bc_op;
    logic [ADDR_W-1:0]   bc_addr, bc_rem, adv_addr, adv_rem, adv_off;
    logic [CLEN_W-1:0]   bc_room, bc_clen;
    logic [CLEN_W-1:0]   cpos_inc;
    logic [7:0]          dev_byte;
    logic [IDX_W-1:0]    host_idx;
    logic [16:0]         cmd_end;
    logic                hb_differs;

    assign acc       = s_valid && s_ready;
    assign req       = req_t'(s_req_type);
    assign s_ready   = room2;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_base_reg   <= 8'd160;
            poll_limit_reg <= 8'd10;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEVICE_BASE: dev_base_reg   <= cfg_data;
                CFG_POLL_LIMIT:  poll_limit_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // advance to the next chunk and chunk sizing
    assign adv_addr   = addr_reg + ADDR_W'(clen_reg);
    assign adv_rem    = rem_reg - ADDR_W'(clen_reg);
    assign adv_off    = off_reg + ADDR_W'(clen_reg);
    assign bc_sel_cmd = (req == REQ_CMD);
    assign bc_op      = bc_sel_cmd ? op_t'(s_op) : oper_reg;
    assign bc_addr    = bc_sel_cmd ? s_start_addr[ADDR_W-1:0] : adv_addr;
    assign bc_rem     = bc_sel_cmd ? s_transfer_len[ADDR_W-1:0] : adv_rem;
    assign bc_room    = (bc_op == OP_READ)
                      ? CLEN_W'(BLOCK_BYTES) - {1'b0, bc_addr[7:0]}
                      : CLEN_W'(PAGE_BYTES) - CLEN_W'(bc_addr % PAGE_BYTES);
    assign bc_clen    = (bc_rem < ADDR_W'(bc_room)) ? bc_rem[CLEN_W-1:0] : bc_room;
    assign cmd_end    = {1'b0, s_start_addr} + {1'b0, s_transfer_len};
    assign cpos_inc   = cpos_reg + 1'b1;
    assign dev_byte   = dev_base_reg | {3'b0, addr_reg[11:8], 1'b0};
    assign hb_differs = buf_rdata != s_host_byte;

    // next state and results
    always_comb begin
        phase_next = phase_reg;
        oper_next  = oper_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        clen_next  = clen_reg;
        cpos_next  = cpos_reg;
        poll_next  = poll_reg;
        diff_next  = diff_reg;
        n_res      = 2'd0;
        r0         = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
        r1         = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
        buf_we     = 1'b0;
        buf_wdata  = s_host_byte;
        host_idx   = '0;
        if (acc) begin
            unique case (req)
                // command
                REQ_CMD: begin
                    if (phase_reg == PH_IDLE && op_t'(s_op) != OP_NONE) begin
                        n_res = 2'd1;
                        if ({1'b0, s_start_addr} >= 17'(MEM_BYTES)) begin
                            r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_ADDR);
                        end else if (cmd_end > 17'(MEM_BYTES)) begin
                            r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_SIZE);
                        end else begin
                            oper_next  = op_t'(s_op);
                            addr_next  = bc_addr;
                            rem_next   = bc_rem;
                            off_next   = '0;
                            poll_next  = '0;
                            if (bc_rem == '0) begin
                                r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_IDLE;
                            end else begin
                                clen_next  = bc_clen;
                                cpos_next  = '0;
                                diff_next  = 1'b0;
                                r0         = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = (bc_op == OP_WRITE) ? PH_WR_START
                                                                 : PH_RD_START;
                            end
                        end
                    end
                end
                // host data byte
                REQ_HOST: begin
                    if (phase_reg == PH_CMP_HOST) begin
                        buf_we    = 1'b1;
                        cpos_next = cpos_inc;
                        if (cpos_inc < clen_reg) begin
                            diff_next = diff_reg | hb_differs;
                            host_idx  = IDX_W'(off_reg) + IDX_W'(cpos_inc);
                            n_res     = 2'd1;
                            r0 = mk_res(K_WANT, 8'd0, 1'b0, host_idx, ST_OK);
                        end else if (diff_reg || hb_differs) begin
                            diff_next  = 1'b1;
                            cpos_next  = '0;
                            n_res      = 2'd1;
                            r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                            phase_next = PH_WR_START;
                        end else begin
                            addr_next = adv_addr;
                            rem_next  = adv_rem;
                            off_next  = adv_off;
                            n_res     = 2'd1;
                            if (adv_rem == '0) begin
                                r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_IDLE;
                            end else begin
                                clen_next  = bc_clen;
                                cpos_next  = '0;
                                diff_next  = 1'b0;
                                r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = (oper_reg == OP_WRITE) ? PH_WR_START
                                                                    : PH_RD_START;
                            end
                        end
                    end else if (phase_reg == PH_WR_HOST) begin
                        n_res      = 2'd1;
                        r0 = mk_res(K_WRITE, s_host_byte, 1'b0, '0, ST_OK);
                        phase_next = PH_WR_DATA;
                    end
                end
                // bus answer
                REQ_BUS: begin
                    n_res = 2'd1;
                    unique case (phase_reg)
                        PH_RD_START, PH_WR_START: begin
                            r0 = mk_res(K_WRITE, dev_byte, 1'b0, '0, ST_OK);
                            phase_next = (phase_reg == PH_RD_START) ? PH_RD_DEV
                                                                    : PH_WR_DEV;
                        end
                        PH_RD_DEV, PH_WR_DEV: begin
                            if (!s_bus_ack) begin
                                r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_ERR_STOP;
                            end else begin
                                r0 = mk_res(K_WRITE, addr_reg[7:0], 1'b0, '0, ST_OK);
                                phase_next = (phase_reg == PH_RD_DEV) ? PH_RD_WORD
                                                                      : PH_WR_WORD;
                            end
                        end
                        PH_RD_WORD: begin
                            if (!s_bus_ack) begin
                                r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_ERR_STOP;
                            end else begin
                                r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_RD_RESTART;
                            end
                        end
                        PH_RD_RESTART: begin
                            r0 = mk_res(K_WRITE, dev_byte | 8'h01, 1'b0, '0, ST_OK);
                            phase_next = PH_RD_DEVR;
                        end
                        PH_RD_DEVR: begin
                            if (!s_bus_ack) begin
                                r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_ERR_STOP;
                            end else begin
                                cpos_next  = '0;
                                r0 = mk_res(K_READ, 8'd0, clen_reg > CLEN_W'(1), '0,
                                            ST_OK);
                                phase_next = PH_RD_DATA;
                            end
                        end
                        PH_RD_DATA: begin
                            cpos_next = cpos_inc;
                            buf_wdata = s_bus_byte;
                            buf_we    = (oper_reg != OP_READ)
                                     && (cpos_reg < CLEN_W'(PAGE_BYTES));
                            host_idx  = IDX_W'(off_reg) + IDX_W'(cpos_reg);
                            if (oper_reg == OP_READ) begin
                                n_res = 2'd2;
                                r0 = mk_res(K_DATA, s_bus_byte, 1'b0, host_idx, ST_OK);
                                if (cpos_inc < clen_reg) begin
                                    r1 = mk_res(K_READ, 8'd0,
                                                (cpos_inc + 1'b1) < clen_reg, '0, ST_OK);
                                end else begin
                                    r1 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                    phase_next = PH_RD_STOP;
                                end
                            end else if (cpos_inc < clen_reg) begin
                                r0 = mk_res(K_READ, 8'd0,
                                            (cpos_inc + 1'b1) < clen_reg, '0, ST_OK);
                            end else begin
                                r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_RD_STOP;
                            end
                        end
                        PH_RD_STOP, PH_PL_OK: begin
                            if (phase_reg == PH_RD_STOP && oper_reg != OP_READ) begin
                                cpos_next  = '0;
                                diff_next  = 1'b0;
                                host_idx   = IDX_W'(off_reg);
                                r0 = mk_res(K_WANT, 8'd0, 1'b0, host_idx, ST_OK);
                                phase_next = PH_CMP_HOST;
                            end else begin
                                addr_next = adv_addr;
                                rem_next  = adv_rem;
                                off_next  = adv_off;
                                if (adv_rem == '0) begin
                                    r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_OK);
                                    phase_next = PH_IDLE;
                                end else begin
                                    clen_next  = bc_clen;
                                    cpos_next  = '0;
                                    diff_next  = 1'b0;
                                    r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                                    phase_next = (oper_reg == OP_WRITE) ? PH_WR_START
                                                                        : PH_RD_START;
                                end
                            end
                        end
                        PH_WR_WORD, PH_WR_DATA: begin
                            if (!s_bus_ack) begin
                                r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                phase_next = PH_ERR_STOP;
                            end else begin
                                cpos_next = (phase_reg == PH_WR_WORD) ? '0 : cpos_inc;
                                if (phase_reg == PH_WR_DATA && cpos_inc >= clen_reg)
                                begin
                                    r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                                    phase_next = PH_WR_STOP;
                                end else if (oper_reg == OP_WRITE) begin
                                    host_idx = IDX_W'(off_reg) + IDX_W'(cpos_next);
                                    r0 = mk_res(K_WANT, 8'd0, 1'b0, host_idx, ST_OK);
                                    phase_next = PH_WR_HOST;
                                end else begin
                                    r0 = mk_res(K_WRITE, buf_rdata, 1'b0, '0, ST_OK);
                                    phase_next = PH_WR_DATA;
                                end
                            end
                        end
                        PH_WR_STOP: begin
                            poll_next  = '0;
                            r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                            phase_next = PH_PL_START;
                        end
                        PH_PL_START: begin
                            r0 = mk_res(K_WRITE, dev_base_reg, 1'b0, '0, ST_OK);
                            phase_next = PH_PL_DEV;
                        end
                        PH_PL_DEV: begin
                            r0 = mk_res(K_STOP, 8'd0, 1'b0, '0, ST_OK);
                            phase_next = s_bus_ack ? PH_PL_OK : PH_PL_FAIL;
                        end
                        PH_PL_FAIL: begin
                            n_res      = 2'd0;
                            phase_next = PH_PL_TICK;
                        end
                        PH_ERR_STOP: begin
                            r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_NACK);
                            phase_next = PH_IDLE;
                        end
                        default: begin
                            n_res = 2'd0;
                        end
                    endcase
                end
                // millisecond tick
                REQ_TICK: begin
                    if (phase_reg == PH_PL_TICK) begin
                        poll_next = (poll_reg != 8'hFF) ? poll_reg + 8'd1 : poll_reg;
                        n_res     = 2'd1;
                        if (poll_next >= poll_limit_reg) begin
                            r0 = mk_res(K_DONE, 8'd0, 1'b0, '0, ST_TIMEOUT);
                            phase_next = PH_IDLE;
                        end else begin
                            r0 = mk_res(K_START, 8'd0, 1'b0, '0, ST_OK);
                            phase_next = PH_PL_START;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // mark the last result of the beat
    always_comb begin
        p0 = r0;
        p1 = r1;
        p0.last = (n_res == 2'd1);
        p1.last = 1'b1;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            oper_reg  <= OP_READ;
            addr_reg  <= '0;
            rem_reg   <= '0;
            off_reg   <= '0;
            clen_reg  <= '0;
            cpos_reg  <= '0;
            poll_reg  <= '0;
            diff_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            oper_reg  <= oper_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            off_reg   <= off_next;
            clen_reg  <= clen_next;
            cpos_reg  <= cpos_next;
            poll_reg  <= poll_next;
            diff_reg  <= diff_next;
        end
    end

    // page buffer read one item ahead: the entry the next beat will need
    always_comb begin
        buf_waddr = cpos_reg[PIDX_W-1:0];
        if (phase_next == PH_WR_DATA) begin
            buf_raddr = cpos_next[PIDX_W-1:0] + 1'b1;
        end else if (phase_next == PH_WR_WORD) begin
            buf_raddr = '0;
        end else begin
            buf_raddr = cpos_next[PIDX_W-1:0];
        end
    end

    i2cee_page_buf #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_page_buf (
        .aclk    (aclk),
        .wr_en   (buf_we),
        .wr_addr (buf_waddr),
        .wr_data (buf_wdata),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    i2cee_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (n_res),
        .push0     (p0),
        .push1     (p1),
        .room2     (room2),
        .pop_valid (m_valid),
        .pop_ready (m_ready),
        .pop_data  (q_out),
        .level     (q_level)
    );

    assign m_out_kind   = q_out.kind;
    assign m_out_byte   = q_out.data;
    assign m_read_ack   = q_out.ack;
    assign m_data_index = q_out.idx;
    assign m_status     = q_out.status;
    assign m_last       = q_out.last;

`ifndef ASSERT_OFF
    // queue never overfills
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= 3'(RES_DEPTH)) else $error("result queue overflow");
    // an accepted beat always finds room for two results
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> q_level <= 3'(RES_DEPTH - 2)) else $error("accepted without room");
    // chunk position never passes chunk length
    a_cpos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> cpos_reg <= clen_reg) else $error("chunk overrun");
`endif
endmodule
